// ===== hdl/sensor_reply_frame_parser_macros.svh =====
//------------------------------------------------------------------------------
// sensor reply frame parser assertion macros
// shared concurrent assertion forms for the parser rtl
//------------------------------------------------------------------------------
`ifndef SENSOR_REPLY_FRAME_PARSER_MACROS_SVH
`define SENSOR_REPLY_FRAME_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define SRFP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SRFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/srfp_pkg.sv =====
//------------------------------------------------------------------------------
// srfp_pkg
// types and constants of the sensor reply frame parser
//------------------------------------------------------------------------------
package srfp_pkg;

	// frame parsing phase
	typedef enum logic [2:0] {
		PH_ADDR = 3'd0,
		PH_FUNC = 3'd1,
		PH_REG  = 3'd2,
		PH_CNT  = 3'd3,
		PH_DATA = 3'd4,
		PH_CSUM = 3'd5
	} phase_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_DEVICE_ADDRESS = 1'b0,
		REG_SENSOR_PORT    = 1'b1
	} cfg_reg_t;

	localparam int          BUFFER_DEPTH_DEFAULT = 16;
	localparam logic [7:0]  FUNC_READ            = 8'h03;
	localparam logic [7:0]  WANT_REG             = 8'h07;
	localparam logic [7:0]  WANT_COUNT           = 8'h07;
	localparam int          RESULT_BYTES         = 7;

endpackage

// ===== hdl/sensor_reply_frame_parser.sv =====
//------------------------------------------------------------------------------
// sensor_reply_frame_parser
// parses read-reply frames from a port-tagged uart byte stream and emits
// emissivity and three temperatures in hundredths of a degree
//------------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  in       | in_valid / in_stall        | uart_port, rx_byte
//  out      | out_valid / out_stall      | emissivity, target/ambient/body temp
//  cfg      | cfg_write (no wait)        | cfg_index, cfg_data
//
//  one byte per cycle while out_stall does not hold the parser: a byte is
//  registered at input, then parsed against the frame state, a result lands
//  in the output register; a result passes the input register and then the
//  output register after the checksum byte transaction, and leaves from there
//  out_stall only holds the parser when a result waits and another byte is in
//  the input register; the input then stalls in the same cycle
//  arst_n clears phase, counters, sum, config and valid flags; the data bytes
//  are not cleared (each result reads only bytes of its own frame)
//
`include "sensor_reply_frame_parser_macros.svh"

module sensor_reply_frame_parser #(
	parameter int BUFFER_DEPTH = srfp_pkg::BUFFER_DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  uart_port,
	input  logic [7:0]  rx_byte,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  emissivity,
	output logic [15:0] target_temp_centi,
	output logic [15:0] ambient_temp_centi,
	output logic [15:0] body_temp_centi
);

	// counter wide enough to hold the depth itself
	localparam int         CW     = $clog2(BUFFER_DEPTH + 1);
	localparam logic [8:0] DEPTH9 = 9'(BUFFER_DEPTH);

	// configuration registers
	logic [7:0] device_address_q;
	logic [3:0] sensor_port_q;

	// input stage
	logic       valid_s1;
	logic [3:0] port_s1;
	logic [7:0] byte_s1;

	// frame state
	srfp_pkg::phase_t phase_q, phase_d;
	logic [CW-1:0]    data_index_q, data_index_d;
	logic [CW-1:0]    expected_count_q, expected_count_d;
	logic [7:0]       start_reg_q, start_reg_d;
	logic [7:0]       sum_q, sum_d;
	logic [CW-1:0]    index_inc;

	// captured data bytes of the current frame (only the ones a result uses)
	logic [7:0] data_q [srfp_pkg::RESULT_BYTES];

	// output register
	logic        out_valid_q;
	logic [7:0]  emissivity_q;
	logic [15:0] target_q;
	logic [15:0] ambient_q;
	logic [15:0] body_q;

	logic in_fire;
	logic out_free;
	logic advance;
	logic port_hit;
	logic clear;
	logic hit;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_fire  = in_valid && !in_stall;
	assign port_hit = advance && (port_s1 == sensor_port_q);
	assign index_inc = data_index_q + CW'(1);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= '0;
			sensor_port_q    <= '0;
		end else if (cfg_write) begin
			unique case (srfp_pkg::cfg_reg_t'(cfg_index))
				srfp_pkg::REG_DEVICE_ADDRESS: device_address_q <= cfg_data;
				srfp_pkg::REG_SENSOR_PORT:    sensor_port_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			port_s1 <= uart_port;
			byte_s1 <= rx_byte;
		end
	end

	// next frame state and result decision
	always_comb begin
		phase_d          = phase_q;
		data_index_d     = data_index_q;
		expected_count_d = expected_count_q;
		start_reg_d      = start_reg_q;
		sum_d            = sum_q;
		clear            = 1'b0;
		hit              = 1'b0;
		if (port_hit) begin
			unique case (phase_q)
				srfp_pkg::PH_ADDR: begin
					// wrong address byte is simply skipped
					if (byte_s1 == device_address_q) begin
						sum_d   = byte_s1;
						phase_d = srfp_pkg::PH_FUNC;
					end
				end
				srfp_pkg::PH_FUNC: begin
					if (byte_s1 == srfp_pkg::FUNC_READ) begin
						sum_d   = sum_q + byte_s1;
						phase_d = srfp_pkg::PH_REG;
					end else begin
						clear = 1'b1;
					end
				end
				srfp_pkg::PH_REG: begin
					start_reg_d = byte_s1;
					sum_d       = sum_q + byte_s1;
					phase_d     = srfp_pkg::PH_CNT;
				end
				srfp_pkg::PH_CNT: begin
					// count beyond buffer depth drops the frame
					if ({1'b0, byte_s1} > DEPTH9) begin
						clear = 1'b1;
					end else begin
						expected_count_d = CW'(byte_s1);
						sum_d            = sum_q + byte_s1;
						data_index_d     = '0;
						phase_d          = (byte_s1 == 8'd0) ? srfp_pkg::PH_CSUM
						                                     : srfp_pkg::PH_DATA;
					end
				end
				srfp_pkg::PH_DATA: begin
					data_index_d = index_inc;
					sum_d        = sum_q + byte_s1;
					if (index_inc >= expected_count_q) begin
						phase_d = srfp_pkg::PH_CSUM;
					end
				end
				srfp_pkg::PH_CSUM: begin
					hit   = (sum_q == byte_s1) &&
					        (start_reg_q == srfp_pkg::WANT_REG) &&
					        (expected_count_q == CW'(srfp_pkg::WANT_COUNT));
					clear = 1'b1;
				end
				default: begin
					clear = 1'b1;
				end
			endcase
			if (clear) begin
				phase_d          = srfp_pkg::PH_ADDR;
				data_index_d     = '0;
				expected_count_d = '0;
				start_reg_d      = '0;
				sum_d            = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= srfp_pkg::PH_ADDR;
			data_index_q     <= '0;
			expected_count_q <= '0;
			start_reg_q      <= '0;
			sum_q            <= '0;
		end else begin
			phase_q          <= phase_d;
			data_index_q     <= data_index_d;
			expected_count_q <= expected_count_d;
			start_reg_q      <= start_reg_d;
			sum_q            <= sum_d;
		end
	end

	// data byte capture, each byte register has its own index decode
	always_ff @(posedge clk) begin
		for (int i = 0; i < srfp_pkg::RESULT_BYTES; i++) begin
			if (port_hit && phase_q == srfp_pkg::PH_DATA && data_index_q == CW'(i)) begin
				data_q[i] <= byte_s1;
			end
		end
	end

	// output register: a new result may replace one taken this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (hit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			emissivity_q <= data_q[0];
			target_q     <= {data_q[1], data_q[2]};
			ambient_q    <= {data_q[3], data_q[4]};
			body_q       <= {data_q[5], data_q[6]};
		end
	end

	assign out_valid          = out_valid_q;
	assign emissivity         = emissivity_q;
	assign target_temp_centi  = target_q;
	assign ambient_temp_centi = ambient_q;
	assign body_temp_centi    = body_q;

	// assertions
	`SRFP_ASSERT_IMPL(a_index_in_count, clk, arst_n, 1'b1, data_index_q <= expected_count_q, "data index beyond expected count")
	`SRFP_ASSERT_IMPL(a_data_count_nonzero, clk, arst_n, phase_q == srfp_pkg::PH_DATA, expected_count_q != '0, "data phase with zero count")
	`SRFP_ASSERT_IMPL(a_addr_phase_clean, clk, arst_n, phase_q == srfp_pkg::PH_ADDR, sum_q == '0 && data_index_q == '0 && expected_count_q == '0, "parser not cleared while waiting for address")
	`SRFP_ASSERT_IMPL(a_result_from_csum, clk, arst_n, $rose(out_valid_q), $past(phase_q) == srfp_pkg::PH_CSUM, "result not caused by a checksum byte")

endmodule
